>>> rtl/tpps_pkg.sv
package tpps_pkg;

	localparam int unsigned CLOCK_MHZ        = 72;
	localparam int unsigned ONE_DIVIDE_LIMIT = 910;

	localparam logic [31:0] DIV_LIMIT  = (ONE_DIVIDE_LIMIT == 0) ? 32'd1 : 32'(ONE_DIVIDE_LIMIT);
	localparam logic [31:0] TICK_MUL   = 32'(CLOCK_MHZ);
	localparam logic [31:0] US_PER_S   = 32'd1000000;
	localparam logic [31:0] US_PER_MS  = 32'd1000;
	localparam logic [15:0] PSC_MAX    = 16'hffff;
	localparam logic [31:0] RELOAD_MAX = 32'h0000ffff;

	localparam logic [1:0] ST_EXACT  = 2'd0;
	localparam logic [1:0] ST_APPROX = 2'd1;
	localparam logic [1:0] ST_RANGE  = 2'd2;

	localparam int unsigned IN_W  = 48;
	localparam int unsigned OUT_W = 56;

	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_AW    = 1;

	typedef struct packed {
		logic [31:0] total;
		logic [31:0] ticks;
	} job_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quo;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

>>> rtl/timer_prescaler_period_search_top.sv
// Turns a period given as seconds, milliseconds and microseconds into a timer
// prescaler and reload count for a 72 MHz counter, searching upward from
// total/910 for a prescaler that divides the tick count exactly with a reload
// of at most 0xffff, else falling back to the base (status 1), or saturating
// at 65535 when the base is too large (status 2). Every division runs through
// one shared radix-2 divider, one at a time: first the base, then one per
// candidate tried (up to 65534 - base), and one more for a fallback result.
// A two-entry queue lets new inputs be taken while a search runs, and a
// finished result waits in the output register.
module timer_prescaler_period_search_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tpps_pkg::IN_W-1:0]     s_tdata,  // seconds, milliseconds, microseconds
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tpps_pkg::OUT_W-1:0]    m_tdata   // prescale, reload, status, zero pad
);

	logic               f_valid, f_ready, b_valid, b_ready;
	tpps_pkg::job_t     f_data, b_data;
	tpps_pkg::div_req_t div_req;
	tpps_pkg::div_rsp_t div_rsp;

	tpps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_data   (f_data)
	);

	tpps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	tpps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tpps_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (b_valid),
		.q_ready  (b_ready),
		.q_data   (b_data),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

`ifndef SYNTH
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[49:48] != 2'd3)
		else $error("bad status code");

	a_exact_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[49:48] == tpps_pkg::ST_EXACT) |-> m_tdata[47:32] == '0)
		else $error("exact result with reload above 0xffff");

	a_range_psc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[49:48] == tpps_pkg::ST_RANGE) |-> m_tdata[15:0] == tpps_pkg::PSC_MAX)
		else $error("out of range result without saturated prescale");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> !div_rsp.done)
		else $error("divider finished right after start");
`endif

endmodule

>>> rtl/tpps_front.sv
module tpps_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tpps_pkg::IN_W-1:0]      s_tdata,
	output logic                           q_valid,
	input  logic                           q_ready,
	output tpps_pkg::job_t                 q_data
);

	logic        v_s1, v_s2, v_s3;
	logic [31:0] p_sec_s1, p_ms_s1, p_us_s1;
	logic [31:0] total_s2;
	logic [31:0] total_s3, ticks_s3;
	logic        adv;

	assign adv      = !v_s3 || q_ready;
	assign s_tready = adv;
	assign q_valid  = v_s3;
	assign q_data   = '{total: total_s3, ticks: ticks_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_sec_s1 <= 32'(s_tdata[15:0]) * tpps_pkg::US_PER_S;
			p_ms_s1  <= 32'(s_tdata[31:16]) * tpps_pkg::US_PER_MS;
			p_us_s1  <= 32'(s_tdata[47:32]);
			total_s2 <= p_sec_s1 + p_ms_s1 + p_us_s1;
			total_s3 <= total_s2;
			ticks_s3 <= total_s2 * tpps_pkg::TICK_MUL;
		end
	end

endmodule

>>> rtl/tpps_queue.sv
module tpps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tpps_pkg::job_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output tpps_pkg::job_t out_data
);

	tpps_pkg::job_t                mem_q [tpps_pkg::Q_DEPTH];
	logic [tpps_pkg::Q_AW-1:0]     wr_q, rd_q;
	logic [tpps_pkg::Q_AW:0]       cnt_q;
	logic                          push, pop;

	assign in_ready  = cnt_q != (tpps_pkg::Q_AW+1)'(tpps_pkg::Q_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (tpps_pkg::Q_AW+1)'(push) - (tpps_pkg::Q_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_data;
	end

endmodule

>>> rtl/tpps_div.sv
module tpps_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tpps_pkg::div_req_t req,
	output tpps_pkg::div_rsp_t rsp
);

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [31:0] dsr_q, rem_q, quo_q;
	logic [32:0] trial;
	logic        ge;
	logic [32:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};
	assign rsp   = '{done: done_q, quo: quo_q, rem: rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

endmodule

>>> rtl/tpps_back.sv
module tpps_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	output logic                        q_ready,
	input  tpps_pkg::job_t              q_data,
	output tpps_pkg::div_req_t          div_req,
	input  tpps_pkg::div_rsp_t          div_rsp,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tpps_pkg::OUT_W-1:0]  m_tdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BASE = 3'd1;
	localparam logic [2:0] S_SRCH = 3'd2;
	localparam logic [2:0] S_FALL = 3'd3;
	localparam logic [2:0] S_HOLD = 3'd4;

	logic [2:0]                  state_q;
	logic                        start_q, ovalid_q;
	logic [31:0]                 dvd_q, dsr_q, ticks_q, reload_q;
	logic [15:0]                 base_q, cand_q, psc_q;
	logic [1:0]                  status_q;
	logic [tpps_pkg::OUT_W-1:0]  odata_q;
	logic [15:0]                 base_w, cand_nx;
	logic                        out_free, hit;

	assign base_w   = (div_rsp.quo == '0) ? 16'd1 : div_rsp.quo[15:0];
	assign cand_nx  = cand_q + 16'd1;
	assign out_free = !ovalid_q || m_tready;
	assign hit      = (div_rsp.rem == '0) && (div_rsp.quo <= tpps_pkg::RELOAD_MAX);
	assign q_ready  = state_q == S_IDLE;
	assign div_req  = '{start: start_q, dividend: dvd_q, divisor: dsr_q};
	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			start_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (ovalid_q && m_tready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						start_q <= 1'b1;
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					if (div_rsp.done) begin
						start_q <= 1'b1;
						if (div_rsp.quo[31:16] != '0 || base_w >= tpps_pkg::PSC_MAX - 16'd1) begin
							state_q <= S_FALL;
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (div_rsp.done) begin
						if (hit) begin
							state_q <= S_HOLD;
						end else begin
							start_q <= 1'b1;
							if (cand_nx == tpps_pkg::PSC_MAX) state_q <= S_FALL;
						end
					end
				end
				S_FALL: begin
					if (div_rsp.done) state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ticks_q <= q_data.ticks;
				dvd_q   <= q_data.total;
				dsr_q   <= tpps_pkg::DIV_LIMIT;
			end
			S_BASE: begin
				dvd_q <= ticks_q;
				if (div_rsp.quo[31:16] != '0) begin
					psc_q    <= tpps_pkg::PSC_MAX;
					status_q <= tpps_pkg::ST_RANGE;
					dsr_q    <= 32'(tpps_pkg::PSC_MAX);
				end else if (base_w >= tpps_pkg::PSC_MAX - 16'd1) begin
					psc_q    <= base_w;
					status_q <= tpps_pkg::ST_APPROX;
					dsr_q    <= 32'(base_w);
				end else begin
					base_q <= base_w;
					cand_q <= base_w + 16'd1;
					dsr_q  <= 32'(base_w + 16'd1);
				end
			end
			S_SRCH: begin
				if (div_rsp.done) begin
					if (hit) begin
						psc_q    <= cand_q;
						reload_q <= div_rsp.quo;
						status_q <= tpps_pkg::ST_EXACT;
					end else if (cand_nx == tpps_pkg::PSC_MAX) begin
						psc_q    <= base_q;
						status_q <= tpps_pkg::ST_APPROX;
						dsr_q    <= 32'(base_q);
					end else begin
						cand_q <= cand_nx;
						dsr_q  <= 32'(cand_nx);
					end
				end
			end
			S_FALL: begin
				if (div_rsp.done) reload_q <= div_rsp.quo;
			end
			S_HOLD: begin
				if (out_free) odata_q <= {6'd0, status_q, reload_q, psc_q};
			end
			default: ;
		endcase
	end

endmodule
